[rtl/core/bcle_pkg.sv]
// Shared constants, codes and types of the bounded circular list engine.
`timescale 1ns / 1ps

package bcle_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int NODE_W     = VALUE_BITS + 2 * IDX_W;

  localparam logic [1:0] OP_INS_TAIL = 2'd0;
  localparam logic [1:0] OP_INS_HEAD = 2'd1;
  localparam logic [1:0] OP_DELETE   = 2'd2;
  localparam logic [1:0] OP_READ_ALL = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      next;
    logic [IDX_W-1:0]      prev;
  } node_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    node_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             set;
    logic [IDX_W-1:0] set_idx;
    logic             clr;
    logic [IDX_W-1:0] clr_idx;
  } alloc_req_t;

  typedef struct packed {
    logic             full;
    logic [IDX_W-1:0] free_idx;
  } alloc_stat_t;

  typedef struct packed {
    logic                  valid;
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      count;
    logic                  last;
  } emit_t;

endpackage

[rtl/core/bcle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bcle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bcle_alloc.sv]
// Slot-in-use flags and lowest-free-slot finder of the node pool.
`timescale 1ns / 1ps

module bcle_alloc import bcle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alloc_req_t  req_i,
  output alloc_stat_t stat_o
);

  logic [CAPACITY-1:0] in_use_q, in_use_d;
  logic [IDX_W-1:0]    free_idx;

  always_comb begin
    in_use_d = in_use_q;
    if (req_i.set) begin
      in_use_d[req_i.set_idx] = 1'b1;
    end
    if (req_i.clr) begin
      in_use_d[req_i.clr_idx] = 1'b0;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (!in_use_q[k]) begin
        free_idx = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else begin
      in_use_q <= in_use_d;
    end
  end

  assign stat_o.full     = &in_use_q;
  assign stat_o.free_idx = free_idx;

endmodule

[rtl/core/bcle_seq.sv]
// Sequencer: read-modify-write of node memory, list walks, head/tail/length.
`timescale 1ns / 1ps

module bcle_seq import bcle_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  emit_ready_i,
  output emit_t                 emit_o,
  output alloc_req_t            alloc_o,
  input  alloc_stat_t           alloc_i,
  output ram_req_t              ram_o,
  input  node_t                 rdata_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DONE     = 4'd1;
  localparam logic [3:0] S_INS_T    = 4'd2;
  localparam logic [3:0] S_INS_HR   = 4'd3;
  localparam logic [3:0] S_INS_H    = 4'd4;
  localparam logic [3:0] S_DEL_WALK = 4'd5;
  localparam logic [3:0] S_DEL_PW   = 4'd6;
  localparam logic [3:0] S_DEL_NR   = 4'd7;
  localparam logic [3:0] S_DEL_NW   = 4'd8;
  localparam logic [3:0] S_RD_WALK  = 4'd9;

  logic [3:0]            state_q, state_d;
  logic [IDX_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]      len_q, len_d;
  logic [CNT_W-1:0]      i_q, i_d;
  logic [IDX_W-1:0]      p_q, p_d, n_q, n_d, nx_q, nx_d, pv_q, pv_d;
  logic [1:0]            op_q, op_d, st_q, st_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  walk_last;

  assign walk_last = (i_q + CNT_W'(1)) == len_q;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    len_d   = len_q;
    i_d     = i_q;
    p_d     = p_q;
    n_d     = n_q;
    nx_d    = nx_q;
    pv_d    = pv_q;
    op_d    = op_q;
    st_d    = st_q;
    val_d   = val_q;
    ram_o   = '0;
    alloc_o = '0;
    emit_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = opcode_i;
          val_d = value_i;
          i_d   = '0;
          unique case (opcode_i)
            OP_INS_TAIL, OP_INS_HEAD: begin
              if (alloc_i.full || len_q >= CNT_W'(CAPACITY)) begin
                st_d    = ST_FULL;
                state_d = S_DONE;
              end else begin
                n_d             = alloc_i.free_idx;
                alloc_o.set     = 1'b1;
                alloc_o.set_idx = alloc_i.free_idx;
                ram_o.we        = 1'b1;
                ram_o.waddr     = alloc_i.free_idx;
                ram_o.wdata.value = value_i;
                if (len_q == '0) begin
                  ram_o.wdata.next = alloc_i.free_idx;
                  ram_o.wdata.prev = alloc_i.free_idx;
                  head_d  = alloc_i.free_idx;
                  tail_d  = alloc_i.free_idx;
                  len_d   = len_q + CNT_W'(1);
                  st_d    = ST_OK;
                  state_d = S_DONE;
                end else begin
                  ram_o.wdata.next = head_q;
                  ram_o.wdata.prev = tail_q;
                  ram_o.re    = 1'b1;
                  ram_o.raddr = tail_q;
                  state_d     = S_INS_T;
                end
              end
            end
            OP_DELETE: begin
              if (len_q == '0) begin
                st_d    = ST_NOTFOUND;
                state_d = S_DONE;
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = head_q;
                p_d         = head_q;
                state_d     = S_DEL_WALK;
              end
            end
            OP_READ_ALL: begin
              if (len_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_DONE;
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = head_q;
                state_d     = S_RD_WALK;
              end
            end
          endcase
        end
      end
      S_INS_T: begin
        ram_o.we          = 1'b1;
        ram_o.waddr       = tail_q;
        ram_o.wdata       = rdata_i;
        ram_o.wdata.next  = n_q;
        state_d           = S_INS_HR;
      end
      S_INS_HR: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = head_q;
        state_d     = S_INS_H;
      end
      S_INS_H: begin
        ram_o.we         = 1'b1;
        ram_o.waddr      = head_q;
        ram_o.wdata      = rdata_i;
        ram_o.wdata.prev = n_q;
        if (op_q == OP_INS_HEAD) begin
          head_d = n_q;
        end else begin
          tail_d = n_q;
        end
        len_d   = len_q + CNT_W'(1);
        st_d    = ST_OK;
        state_d = S_DONE;
      end
      S_DEL_WALK: begin
        if (rdata_i.value == val_q) begin
          alloc_o.clr     = 1'b1;
          alloc_o.clr_idx = p_q;
          if (len_q > CNT_W'(1)) begin
            nx_d = rdata_i.next;
            pv_d = rdata_i.prev;
            if (p_q == head_q) begin
              head_d = rdata_i.next;
            end else if (p_q == tail_q) begin
              tail_d = rdata_i.prev;
            end
            ram_o.re    = 1'b1;
            ram_o.raddr = rdata_i.prev;
            state_d     = S_DEL_PW;
          end else begin
            len_d   = len_q - CNT_W'(1);
            st_d    = ST_OK;
            state_d = S_DONE;
          end
        end else if (walk_last) begin
          st_d    = ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = rdata_i.next;
          p_d         = rdata_i.next;
          i_d         = i_q + CNT_W'(1);
        end
      end
      S_DEL_PW: begin
        ram_o.we         = 1'b1;
        ram_o.waddr      = pv_q;
        ram_o.wdata      = rdata_i;
        ram_o.wdata.next = nx_q;
        state_d          = S_DEL_NR;
      end
      S_DEL_NR: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = nx_q;
        state_d     = S_DEL_NW;
      end
      S_DEL_NW: begin
        ram_o.we         = 1'b1;
        ram_o.waddr      = nx_q;
        ram_o.wdata      = rdata_i;
        ram_o.wdata.prev = pv_q;
        len_d            = len_q - CNT_W'(1);
        st_d             = ST_OK;
        state_d          = S_DONE;
      end
      S_RD_WALK: begin
        emit_o.valid  = 1'b1;
        emit_o.status = ST_OK;
        emit_o.value  = rdata_i.value;
        emit_o.count  = len_q;
        emit_o.last   = walk_last;
        if (emit_ready_i) begin
          if (walk_last) begin
            state_d = S_IDLE;
          end else begin
            ram_o.re    = 1'b1;
            ram_o.raddr = rdata_i.next;
            i_d         = i_q + CNT_W'(1);
          end
        end
      end
      S_DONE: begin
        emit_o.valid  = 1'b1;
        emit_o.status = st_q;
        emit_o.value  = '0;
        emit_o.count  = len_q;
        emit_o.last   = 1'b1;
        if (emit_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      len_q   <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      len_q   <= len_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    n_q   <= n_d;
    nx_q  <= nx_d;
    pv_q  <= pv_d;
    op_q  <= op_d;
    st_q  <= st_d;
    val_q <= val_d;
  end

  // read of an entry being written in the same cycle would return stale data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_o.we && ram_o.re) |-> (ram_o.waddr != ram_o.raddr))
    else $error("node memory read and write collide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_o.set |-> !alloc_i.full)
    else $error("slot allocated from full pool");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new item taken before previous one finished");

endmodule

[rtl/core/bounded_circular_list_engine.sv]
// Top level of the bounded circular list engine: node memory, pool, sequencer, output register.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   opcode_i, element_value_i
//   out      output     out_valid_o / out_ready_i status_o, read_value_o,
//                                                 element_count_o, last_result_o
//
// One item at a time; node memory paces it, one linked entry per cycle unless output stalls.
// Insert writes the new node, then relinks tail and head (only the node write on an empty
// list, nothing on a full pool); delete walks from the head, then unlinks a match.
// Read all walks from the head, one result per cycle while out_ready_i is high.
// Reset clears the slot flags, head, tail and length at once; no clearing pass.
// A stalled output holds the walk in place; the next item is taken after the last result.
`timescale 1ns / 1ps

module bounded_circular_list_engine import bcle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic signed [31:0]  element_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  read_value_o,
  output logic [CNT_W-1:0]    element_count_o,
  output logic                last_result_o
);

  ram_req_t    ram_req;
  node_t       rdata;
  logic [NODE_W-1:0] rdata_raw;
  alloc_req_t  alloc_req;
  alloc_stat_t alloc_stat;
  emit_t       emit;
  logic        emit_ready;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [31:0]       value_q;
  logic [CNT_W-1:0]  count_q;
  logic              last_q;

  bcle_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CAPACITY)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = rdata_raw;

  bcle_alloc u_alloc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alloc_req),
    .stat_o (alloc_stat)
  );

  bcle_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .value_i      (element_value_i[VALUE_BITS-1:0]),
    .emit_ready_i (emit_ready),
    .emit_o       (emit),
    .alloc_o      (alloc_req),
    .alloc_i      (alloc_stat),
    .ram_o        (ram_req),
    .rdata_i      (rdata)
  );

  assign emit_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid && emit_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && emit_ready) begin
      status_q <= emit.status;
      value_q  <= 32'(emit.value);
      count_q  <= emit.count;
      last_q   <= emit.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign read_value_o    = value_q;
  assign element_count_o = count_q;
  assign last_result_o   = last_q;

endmodule

[verif/bounded_circular_list_engine_test.sv]
// Self-checking testbench for the bounded circular list engine: directed and random list traffic.
`timescale 1ns / 1ps

module bounded_circular_list_engine_test;
  import bcle_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      value;
    logic [CNT_W-1:0] count;
    logic             last;
  } list_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          opcode_i = OP_READ_ALL;
  logic signed [31:0]  element_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          status_o;
  logic signed [31:0]  read_value_o;
  logic [CNT_W-1:0]    element_count_o;
  logic                last_result_o;

  bounded_circular_list_engine uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .element_count_o (element_count_o),
    .last_result_o   (last_result_o)
  );

  // shadow list state
  logic signed [31:0] node_val  [CAPACITY];
  logic [IDX_W-1:0]   node_next [CAPACITY];
  logic [IDX_W-1:0]   node_prev [CAPACITY];
  logic               slot_used [CAPACITY];
  logic [IDX_W-1:0]   head_idx;
  logic [IDX_W-1:0]   tail_idx;
  int                 list_len;

  list_result_t expected_results[$];
  int           error_count;
  int           burst_left;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_result(logic [1:0] st, logic [31:0] val, logic last);
    list_result_t r;
    r.status = st;
    r.value  = val;
    r.count  = CNT_W'(list_len);
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  function automatic logic signed [31:0] value_at(int pos);
    logic [IDX_W-1:0] p;
    p = head_idx;
    for (int i = 0; i < pos; i++) p = node_next[p];
    return node_val[p];
  endfunction

  function automatic logic value_present(logic signed [31:0] val);
    for (int i = 0; i < list_len; i++) begin
      if (value_at(i) == val) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_list_op(logic [1:0] op, logic signed [31:0] val);
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] pv;
    logic             found;
    int               n;
    p     = head_idx;
    found = 1'b0;
    n     = 0;
    case (op)
      OP_READ_ALL: begin
        if (list_len == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            push_result(ST_OK, node_val[p], i == list_len - 1);
            p = node_next[p];
          end
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < list_len; i++) begin
          if (node_val[p] == val) begin
            found = 1'b1;
            break;
          end
          p = node_next[p];
        end
        if (!found) begin
          push_result(ST_NOTFOUND, '0, 1'b1);
        end else begin
          if (list_len > 1) begin
            nx = node_next[p];
            pv = node_prev[p];
            node_next[pv] = nx;
            node_prev[nx] = pv;
            if (p == head_idx) head_idx = nx;
            else if (p == tail_idx) tail_idx = pv;
          end
          slot_used[p] = 1'b0;
          list_len--;
          push_result(ST_OK, '0, 1'b1);
        end
      end
      default: begin
        while (n < CAPACITY && slot_used[n]) n++;
        if (n >= CAPACITY || list_len >= CAPACITY) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          slot_used[n] = 1'b1;
          node_val[n]  = val;
          if (list_len == 0) begin
            node_next[n] = IDX_W'(n);
            node_prev[n] = IDX_W'(n);
            head_idx     = IDX_W'(n);
            tail_idx     = IDX_W'(n);
          end else begin
            node_next[n]        = head_idx;
            node_prev[n]        = tail_idx;
            node_next[tail_idx] = IDX_W'(n);
            node_prev[head_idx] = IDX_W'(n);
            if (op == OP_INS_HEAD) head_idx = IDX_W'(n);
            else tail_idx = IDX_W'(n);
          end
          list_len++;
          push_result(ST_OK, '0, 1'b1);
        end
      end
    endcase
  endfunction

  // one item; valid is left high after acceptance so back-to-back items need no toggle
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] val);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    element_value_i <= val;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_list_op(op, val);
  endtask

  task automatic wait_list_idle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (expected_results.size() != 0 && guard < 50000);
    repeat (30) @(posedge clk_i);
  endtask

  // result checker; inputs change only at rising edges, so the falling edge sees settled values
  always @(negedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d count %0d last %0d",
               status_o, read_value_o, element_count_o, last_result_o);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          error_count++;
        end
        if (read_value_o !== exp_r.value) begin
          $error("read_value: expected %0d, got %0d", $signed(exp_r.value), read_value_o);
          error_count++;
        end
        if (element_count_o !== exp_r.count) begin
          $error("element_count: expected %0d, got %0d", exp_r.count, element_count_o);
          error_count++;
        end
        if (last_result_o !== exp_r.last) begin
          $error("last_result: expected %0d, got %0d", exp_r.last, last_result_o);
          error_count++;
        end
      end
    end
  end

  // output back-pressure in four modes, each held for a random span
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ~out_ready_i;
          default: out_ready_i <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  task automatic test_empty_list();
    send_item(OP_READ_ALL, $urandom);
    send_item(OP_DELETE, 32'sd0);
    wait_list_idle();
  endtask

  task automatic test_single_element();
    send_item(OP_INS_TAIL, 32'sd5);
    send_item(OP_DELETE, 32'sd5);
    send_item(OP_READ_ALL, 32'sd0);
    wait_list_idle();
  endtask

  task automatic test_fill_and_overflow();
    logic [1:0] op;
    send_item(OP_INS_TAIL, 32'sd0);
    send_item(OP_INS_HEAD, 32'sh8000_0000);
    send_item(OP_INS_TAIL, 32'sh7fff_ffff);
    send_item(OP_INS_TAIL, -32'sd1);
    for (int i = 0; i < CAPACITY - 4; i++) begin
      op = ($urandom_range(0, 1) != 0) ? OP_INS_HEAD : OP_INS_TAIL;
      send_item(op, (i % 3 == 0) ? 32'sd0 : $signed($urandom));
    end
    send_item(OP_INS_TAIL, $urandom);
    send_item(OP_INS_HEAD, $urandom);
    send_item(OP_READ_ALL, $urandom);
    wait_list_idle();
  endtask

  task automatic test_unlink_positions();
    logic signed [31:0] missing;
    missing = $urandom;
    while (value_present(missing)) missing = $urandom;
    send_item(OP_DELETE, missing);
    send_item(OP_DELETE, 32'sd0);
    send_item(OP_DELETE, value_at(0));
    send_item(OP_DELETE, value_at(list_len - 1));
    send_item(OP_READ_ALL, 32'sd0);
    wait_list_idle();
  endtask

  // alternating grow and shrink phases sweep the list length across its range
  task automatic test_random_traffic();
    int                 r;
    logic [1:0]         op;
    logic signed [31:0] val;
    logic               grow;
    for (int seg = 0; seg < 5; seg++) begin
      grow = (seg % 2 == 0);
      for (int k = 0; k < 50; k++) begin
        r = $urandom_range(0, 99);
        if (r < (grow ? 55 : 25)) begin
          op = ($urandom_range(0, 1) != 0) ? OP_INS_HEAD : OP_INS_TAIL;
        end else if (r < 85) begin
          op = OP_DELETE;
        end else begin
          op = OP_READ_ALL;
        end
        case ($urandom_range(0, 3))
          0: val = $urandom;
          1: val = $urandom_range(0, 7);
          2: val = -$signed({29'd0, 3'($urandom_range(0, 7))}) - 32'sd1;
          default: val = (list_len != 0) ? value_at($urandom_range(0, list_len - 1))
                                         : $signed($urandom);
        endcase
        if (op == OP_DELETE && list_len != 0 && $urandom_range(0, 3) != 0) begin
          val = value_at($urandom_range(0, list_len - 1));
        end
        send_item(op, val);
      end
      wait_list_idle();
    end
  endtask

  initial begin
    error_count = 0;
    burst_left  = 0;
    list_len    = 0;
    head_idx    = '0;
    tail_idx    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_used[i] = 1'b0;
      node_val[i]  = '0;
      node_next[i] = '0;
      node_prev[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_single_element();
    test_fill_and_overflow();
    test_unlink_positions();
    test_random_traffic();

    wait_list_idle();
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/bcle_pkg.sv
rtl/core/bcle_ram.sv
rtl/core/bcle_alloc.sv
rtl/core/bcle_seq.sv
rtl/core/bounded_circular_list_engine.sv
verif/bounded_circular_list_engine_test.sv
